// ----- hw/rtl/gsr_pkg.sv -----
`default_nettype none
package gsr_pkg;

  // grid size and field widths
  localparam int GRID_LINES = 15;
  localparam int IDX_W      = $clog2(GRID_LINES + 1);
  localparam int POS_W      = 16;
  localparam int CELL_W     = 10;
  localparam int ROAD_W     = 8;
  localparam int PITCH_W    = 11;
  localparam int HALF_W     = ROAD_W - 1;
  localparam int PITCH_MAX  = (1 << CELL_W) - 1 + (1 << ROAD_W) - 1;

  // snap thresholds run over odd multiples of the pitch
  localparam int THR_W = $clog2((2 * GRID_LINES + 1) * PITCH_MAX + 1);
  localparam int CMP_W = (THR_W > POS_W + 1) ? THR_W : POS_W + 1;

  // front to back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register file
  localparam int APB_W      = 32;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = ADDR_W - 2;
  localparam int CELL_RESET = 64;
  localparam int ROAD_RESET = 16;
  localparam logic [REG_IDX_W-1:0] REG_CELL = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ROAD = 1'b1;

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [HALF_W-1:0]  half;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] sc;
    logic [IDX_W-1:0] sr;
    logic [IDX_W-1:0] ec;
    logic [IDX_W-1:0] er;
    logic [POS_W-1:0] sx_node;
    logic [POS_W-1:0] sy_node;
    logic [POS_W-1:0] ex;
    logic [POS_W-1:0] ey;
  } job_t;

endpackage
`default_nettype wire

// ----- hw/rtl/grid_snap_xy_route_unit.sv -----
// flow: a taken request is snapped over GRID_LINES threshold steps, written to the job queue
//   and loaded by the back; waypoints then leave one per cycle while pop keeps up, with a turn
//   after the columns and after the rows; results <= 2*GRID_LINES+3 per request,
//   snapping and emission overlap through a two-entry job queue; pop stalls hold emission
// reset (rst, synchronous): the job queue, state machines and the result slot clear,
//   block_len returns to 64 and road_len to 16
`default_nettype none
module grid_snap_xy_route_unit (
  input  logic                       clk,
  input  logic                       rst,
  // request side
  input  logic                       push,
  output logic                       full,
  input  logic [gsr_pkg::POS_W-1:0]  start_x,
  input  logic [gsr_pkg::POS_W-1:0]  start_y,
  input  logic [gsr_pkg::POS_W-1:0]  end_x,
  input  logic [gsr_pkg::POS_W-1:0]  end_y,
  // waypoint side
  output logic                       empty,
  input  logic                       pop,
  output logic [gsr_pkg::POS_W-1:0]  point_x,
  output logic [gsr_pkg::POS_W-1:0]  point_y,
  output logic                       last,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gsr_pkg::ADDR_W-1:0] paddr,
  input  logic [gsr_pkg::APB_W-1:0]  pwdata,
  output logic [gsr_pkg::APB_W-1:0]  prdata,
  output logic                       pready
);
  import gsr_pkg::*;

  logic [CELL_W-1:0]    block_len;
  logic [ROAD_W-1:0]    road_len;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;
  cfg_t                 cfg;

  job_t front_job;
  logic front_job_valid;
  job_t queue_job;
  logic queue_full;
  logic queue_empty;
  logic back_pop;

  // register file: word addressed, byte offset bits ignored
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_len <= CELL_W'(CELL_RESET);
      road_len  <= ROAD_W'(ROAD_RESET);
    end else if (reg_wr) begin
      case (reg_idx)
        REG_CELL: block_len <= pwdata[CELL_W-1:0];
        REG_ROAD: road_len  <= pwdata[ROAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CELL: prdata = APB_W'(block_len);
      REG_ROAD: prdata = APB_W'(road_len);
      default:  prdata = '0;
    endcase
  end

  // node pitch and offset, truncating half of the road
  assign cfg.pitch = PITCH_W'(block_len) + PITCH_W'(road_len);
  assign cfg.half  = road_len[ROAD_W-1:1];

  // front: takes a request and snaps all four coordinates in parallel,
  // one candidate node index per cycle against a shared running threshold
  gsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .job_valid (front_job_valid),
    .job       (front_job),
    .job_full  (queue_full)
  );

  // snapped jobs wait here so the front can start on the next request
  gsr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_job_valid),
    .wr_data (front_job),
    .full    (queue_full),
    .rd_en   (back_pop),
    .rd_data (queue_job),
    .empty   (queue_empty)
  );

  // back: walks the start row, then the end column, into a one-item result slot
  gsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (queue_empty),
    .job       (queue_job),
    .job_pop   (back_pop),
    .empty     (empty),
    .pop       (pop),
    .point_x   (point_x),
    .point_y   (point_y),
    .last      (last)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/gsr_front.sv -----
`default_nettype none
module gsr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  gsr_pkg::cfg_t               cfg,
  input  logic                        push,
  output logic                        full,
  input  logic [gsr_pkg::POS_W-1:0]   start_x,
  input  logic [gsr_pkg::POS_W-1:0]   start_y,
  input  logic [gsr_pkg::POS_W-1:0]   end_x,
  input  logic [gsr_pkg::POS_W-1:0]   end_y,
  output logic                        job_valid,
  output gsr_pkg::job_t               job,
  input  logic                        job_full
);
  import gsr_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RUN  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]       state;
  logic [IDX_W-1:0] step;
  logic [CMP_W-1:0] thresh;
  logic [CMP_W-1:0] d2 [4];
  logic [IDX_W-1:0] q [4];
  logic [POS_W-1:0] sx_node;
  logic [POS_W-1:0] sy_node;
  logic [POS_W-1:0] ex;
  logic [POS_W-1:0] ey;
  logic [3:0]       inc;

  // twice the distance past the first node, zero at or below it or when the pitch is zero
  function automatic logic [CMP_W-1:0] dist2(input logic [POS_W-1:0] pos,
                                             input logic [HALF_W-1:0] half,
                                             input logic pitch_zero);
    logic [POS_W-1:0] d;
    d = pos - POS_W'(half);
    if (pitch_zero || pos <= POS_W'(half)) return '0;
    return CMP_W'({d, 1'b0});
  endfunction

  // one threshold per step: index k wins when 2d > (2k-1)*pitch
  always_comb begin
    for (int a = 0; a < 4; a++) inc[a] = d2[a] > thresh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            d2[0]   <= dist2(start_x, cfg.half, cfg.pitch == '0);
            d2[1]   <= dist2(start_y, cfg.half, cfg.pitch == '0);
            d2[2]   <= dist2(end_x, cfg.half, cfg.pitch == '0);
            d2[3]   <= dist2(end_y, cfg.half, cfg.pitch == '0);
            for (int a = 0; a < 4; a++) q[a] <= '0;
            sx_node <= POS_W'(cfg.half);
            sy_node <= POS_W'(cfg.half);
            ex      <= end_x;
            ey      <= end_y;
            thresh  <= CMP_W'(cfg.pitch);
            step    <= IDX_W'(1);
            state   <= F_RUN;
          end
        end
        F_RUN: begin
          for (int a = 0; a < 4; a++) q[a] <= q[a] + IDX_W'(inc[a]);
          if (inc[0]) sx_node <= sx_node + POS_W'(cfg.pitch);
          if (inc[1]) sy_node <= sy_node + POS_W'(cfg.pitch);
          thresh <= thresh + CMP_W'({cfg.pitch, 1'b0});
          if (step == IDX_W'(GRID_LINES)) state <= F_PUSH;
          else step <= step + IDX_W'(1);
        end
        F_PUSH: begin
          if (!job_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign full      = state != F_IDLE;
  assign job_valid = state == F_PUSH;

  always_comb begin
    job.sc      = q[0];
    job.sr      = q[1];
    job.ec      = q[2];
    job.er      = q[3];
    job.sx_node = sx_node;
    job.sy_node = sy_node;
    job.ex      = ex;
    job.ey      = ey;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/gsr_queue.sv -----
`default_nettype none
module gsr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  gsr_pkg::job_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output gsr_pkg::job_t rd_data,
  output logic          empty
);
  import gsr_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) count <= count + QCNT_W'(1);
      else if (do_rd && !do_wr) count <= count - QCNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/gsr_back.sv -----
`default_nettype none
module gsr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  gsr_pkg::cfg_t             cfg,
  input  logic                      job_empty,
  input  gsr_pkg::job_t             job,
  output logic                      job_pop,
  output logic                      empty,
  input  logic                      pop,
  output logic [gsr_pkg::POS_W-1:0] point_x,
  output logic [gsr_pkg::POS_W-1:0] point_y,
  output logic                      last
);
  import gsr_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_START = 3'd1;
  localparam logic [2:0] B_COLS  = 3'd2;
  localparam logic [2:0] B_ROWS  = 3'd3;
  localparam logic [2:0] B_END   = 3'd4;
  localparam logic [2:0] B_RAW   = 3'd5;

  logic [2:0]       bstate;
  logic             out_valid;
  logic             out_free;
  logic             emit_now;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] ec;
  logic [IDX_W-1:0] er;
  logic [POS_W-1:0] xc;
  logic [POS_W-1:0] yc;
  logic [POS_W-1:0] ex;
  logic [POS_W-1:0] ey;
  logic [IDX_W-1:0] col_next;
  logic [IDX_W-1:0] row_next;
  logic [POS_W-1:0] xc_next;
  logic [POS_W-1:0] yc_next;

  assign out_free = !out_valid || pop;
  assign job_pop  = bstate == B_IDLE && !job_empty;
  assign empty    = !out_valid;

  // a new item goes into the result slot this cycle
  always_comb begin
    case (bstate)
      B_START: emit_now = out_free;
      B_COLS:  emit_now = out_free && (col != ec);
      B_ROWS:  emit_now = out_free && (row != er);
      B_END:   emit_now = out_free;
      B_RAW:   emit_now = out_free;
      default: emit_now = 1'b0;
    endcase
  end

  // one grid step toward the target on each axis, coordinates wrap at 16 bits
  always_comb begin
    if (ec > col) begin
      col_next = col + IDX_W'(1);
      xc_next  = xc + POS_W'(cfg.pitch);
    end else begin
      col_next = col - IDX_W'(1);
      xc_next  = xc - POS_W'(cfg.pitch);
    end
    if (er > row) begin
      row_next = row + IDX_W'(1);
      yc_next  = yc + POS_W'(cfg.pitch);
    end else begin
      row_next = row - IDX_W'(1);
      yc_next  = yc - POS_W'(cfg.pitch);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit_now) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      case (bstate)
        B_IDLE: begin
          if (!job_empty) begin
            col    <= job.sc;
            row    <= job.sr;
            ec     <= job.ec;
            er     <= job.er;
            xc     <= job.sx_node;
            yc     <= job.sy_node;
            ex     <= job.ex;
            ey     <= job.ey;
            bstate <= B_START;
          end
        end
        B_START: begin
          if (out_free) begin
            point_x   <= xc;
            point_y   <= yc;
            last      <= 1'b0;
            bstate    <= B_COLS;
          end
        end
        B_COLS: begin
          if (out_free) begin
            if (col != ec) begin
              col       <= col_next;
              xc        <= xc_next;
              point_x   <= xc_next;
              point_y   <= yc;
              last      <= 1'b0;
            end else begin
              bstate <= B_ROWS;
            end
          end
        end
        B_ROWS: begin
          if (out_free) begin
            if (row != er) begin
              row       <= row_next;
              yc        <= yc_next;
              point_x   <= xc;
              point_y   <= yc_next;
              last      <= 1'b0;
            end else begin
              bstate <= B_END;
            end
          end
        end
        B_END: begin
          if (out_free) begin
            point_x   <= xc;
            point_y   <= yc;
            last      <= 1'b0;
            bstate    <= B_RAW;
          end
        end
        B_RAW: begin
          if (out_free) begin
            point_x   <= ex;
            point_y   <= ey;
            last      <= 1'b1;
            bstate    <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/gsr_checker.sv -----
`default_nettype none
module gsr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      push,
  input logic                      full,
  input logic                      pop,
  input logic                      empty,
  input logic [gsr_pkg::POS_W-1:0] point_x,
  input logic [gsr_pkg::POS_W-1:0] point_y,
  input logic                      last,
  input logic                      pready
);

  // both sides come out of reset idle
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not idle after reset");

  // an accepted request occupies the front while it is snapped
  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("front free right after a request");

  // a waiting item holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(point_x) && $stable(point_y) && $stable(last)))
    else $error("waiting item changed");

  // a route never ends on two items in a row
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && last) |=> (empty || !last))
    else $error("two final items in a row");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind grid_snap_xy_route_unit gsr_checker u_gsr_checker (.*);
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

typedef struct {
  logic [gsr_pkg::POS_W-1:0] x;
  logic [gsr_pkg::POS_W-1:0] y;
  logic                      last;
} waypoint_t;

typedef struct {
  logic [gsr_pkg::POS_W-1:0] sx;
  logic [gsr_pkg::POS_W-1:0] sy;
  logic [gsr_pkg::POS_W-1:0] ex;
  logic [gsr_pkg::POS_W-1:0] ey;
} route_req_t;

// holds the register copy and the waypoints still owed by the block
class waypoint_book;
  int unsigned block_len = gsr_pkg::CELL_RESET;
  int unsigned road_len  = gsr_pkg::ROAD_RESET;
  waypoint_t   planned[$];
  int          mismatches;

  function void set_register(logic [gsr_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
    if (idx == gsr_pkg::REG_CELL) block_len = value[gsr_pkg::CELL_W-1:0];
    else if (idx == gsr_pkg::REG_ROAD) road_len = value[gsr_pkg::ROAD_W-1:0];
  endfunction

  // nearest grid line, lower index on a tie, clamped to the last line
  function int unsigned snap_line(int unsigned pos, int unsigned pitch, int unsigned half);
    int unsigned d, q, r;
    if (pitch == 0 || pos <= half) return 0;
    d = pos - half;
    q = d / pitch;
    r = d % pitch;
    if (2 * r > pitch) q++;
    if (q > gsr_pkg::GRID_LINES) q = gsr_pkg::GRID_LINES;
    return q;
  endfunction

  function logic [15:0] node_pos(int unsigned idx, int unsigned pitch, int unsigned half);
    return 16'(idx * pitch + half);
  endfunction

  function void add_point(logic [15:0] x, logic [15:0] y, logic last);
    waypoint_t w;
    w.x = x;
    w.y = y;
    w.last = last;
    planned = {planned, w};
  endfunction

  // x first along the start row, then y along the end column
  function void plan_route(route_req_t req);
    int unsigned pitch, half, sc, sr, ec, er, c, r;
    logic [15:0] row_y, col_x;
    pitch = block_len + road_len;
    half  = road_len / 2;
    sc = snap_line(req.sx, pitch, half);
    sr = snap_line(req.sy, pitch, half);
    ec = snap_line(req.ex, pitch, half);
    er = snap_line(req.ey, pitch, half);
    row_y = node_pos(sr, pitch, half);
    col_x = node_pos(ec, pitch, half);
    add_point(node_pos(sc, pitch, half), row_y, 1'b0);
    c = sc;
    while (c != ec) begin
      c = (ec > c) ? c + 1 : c - 1;
      add_point(node_pos(c, pitch, half), row_y, 1'b0);
    end
    r = sr;
    while (r != er) begin
      r = (er > r) ? r + 1 : r - 1;
      add_point(col_x, node_pos(r, pitch, half), 1'b0);
    end
    add_point(col_x, node_pos(er, pitch, half), 1'b0);
    add_point(req.ex, req.ey, 1'b1);
  endfunction

  task flag_mismatch(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task match_waypoint(logic [15:0] x, logic [15:0] y, logic last);
    waypoint_t w;
    if (planned.size() == 0) begin
      flag_mismatch($sformatf("unexpected waypoint (%0d,%0d) last=%0b", x, y, last));
    end else begin
      w = planned.pop_front();
      if (x !== w.x) flag_mismatch($sformatf("point_x %0d, wanted %0d", x, w.x));
      if (y !== w.y) flag_mismatch($sformatf("point_y %0d, wanted %0d", y, w.y));
      if (last !== w.last) flag_mismatch($sformatf("last %0b, wanted %0b", last, w.last));
    end
  endtask
endclass

module tb;
  import gsr_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int NUM_PHASES  = 8;
  localparam int RANDOM_PER_PHASE = 15;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic [POS_W-1:0]  start_x, start_y, end_x, end_y;
  logic              empty;
  logic              pop;
  logic [POS_W-1:0]  point_x, point_y;
  logic              last;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  waypoint_book book = new();

  // stimulus-side view of the configuration, used to aim positions at the grid
  int unsigned cfg_cell = CELL_RESET;
  int unsigned cfg_road = ROAD_RESET;
  bit          steady;      // phase without any idling on either side
  int          pop_hold;
  int          quiet_cycles = 0;

  grid_snap_xy_route_unit dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .empty(empty), .pop(pop),
    .point_x(point_x), .point_y(point_y), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function route_req_t mk(int unsigned sx, int unsigned sy, int unsigned ex, int unsigned ey);
    route_req_t q;
    q.sx = sx;
    q.sy = sy;
    q.ex = ex;
    q.ey = ey;
    return q;
  endfunction

  // position biased toward the grid area and the midpoints between lines
  function int unsigned aim_pos();
    int unsigned pitch, half, span, mid;
    pitch = cfg_cell + cfg_road;
    half  = cfg_road / 2;
    span  = pitch * (GRID_LINES + 1) + half;
    if (span > 65535) span = 65535;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535);
      1, 2: return $urandom_range(0, span);
      default: begin
        mid = $urandom_range(0, GRID_LINES) * pitch + half + pitch / 2 + $urandom_range(0, 2);
        return (mid == 0) ? 0 : mid - 1;
      end
    endcase
  endfunction

  // a request goes out on a falling edge and stays until push && !full
  task send_route(route_req_t req);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push    <= 1'b1;
    start_x <= req.sx;
    start_y <= req.sy;
    end_x   <= req.ex;
    end_y   <= req.ey;
    do @(posedge clk); while (full);
    book.plan_route(req);
  endtask

  // register write, then a read back of the same register
  task write_register(logic [REG_IDX_W-1:0] idx, int unsigned value);
    logic [APB_W-1:0] want;
    want = (idx == REG_CELL) ? value & ((1 << CELL_W) - 1) : value & ((1 << ROAD_W) - 1);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_register(idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      book.flag_mismatch($sformatf("register %0d reads %0d, wanted %0d", idx, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // all owed waypoints back, then room for a request still in the snap stage
  task drain_routes();
    @(negedge clk);
    push <= 1'b0;
    while (book.planned.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // waypoint side: pop held high for a cycle, then a random stall
  initial begin
    pop = 1'b0;
    pop_hold = 0;
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= 1'b1;
        pop_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) book.match_waypoint(point_x, point_y, last);
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned cell_tab [NUM_PHASES];
    int unsigned road_tab [NUM_PHASES];
    route_req_t  req;
    rst = 1'b1;
    push = 1'b0;
    start_x = '0;
    start_y = '0;
    end_x = '0;
    end_y = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    // reset values first, then extremes, zero pitch, zero offset, a random pair
    cell_tab = '{64, 1, 1023, 0, 1, 1023, 5, 64};
    road_tab = '{16, 0, 255, 0, 1, 0, 255, 16};
    cell_tab[NUM_PHASES-1] = $urandom_range(1, 1023);
    road_tab[NUM_PHASES-1] = $urandom_range(0, 255);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        drain_routes();
        write_register(REG_CELL, cell_tab[ph]);
        write_register(REG_ROAD, road_tab[ph]);
        cfg_cell = cell_tab[ph];
        cfg_road = road_tab[ph];
      end
      steady = (ph == 1 || ph == 5);

      if (ph == 0) begin
        // pitch 80, offset 8: lines at 8, 88, .. 1208, midpoints 48, 128, ..
        send_route(mk(0, 0, 0, 0));
        send_route(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_route(mk(0, 0, 16'hFFFF, 16'hFFFF));     // longest route
        send_route(mk(16'hFFFF, 16'hFFFF, 0, 0));     // longest route, backwards
        send_route(mk(48, 48, 49, 49));               // tie goes low, one past goes high
        send_route(mk(128, 208, 48, 49));
        send_route(mk(8, 8, 9, 9));                   // at and just past the offset
        send_route(mk(1248, 1249, 1208, 1288));       // beyond the last line
        send_route(mk(100, 100, 90, 85));             // same node at both ends
        send_route(mk(8, 500, 1208, 500));            // columns only
        send_route(mk(500, 8, 500, 1208));            // rows only
        send_route(mk(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
        send_route(mk(1234, 777, 333, 999));
      end else if (ph == 2) begin
        // pitch 1278, offset 127
        send_route(mk(127, 128, 766, 767));
        send_route(mk(0, 19297, 19297, 0));
      end else if (ph == 3) begin
        // zero pitch: everything lands on line 0
        send_route(mk(0, 0, 16'hFFFF, 16'hFFFF));
        send_route(mk(1, 1, 0, 0));
      end

      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        req = mk(aim_pos(), aim_pos(), aim_pos(), aim_pos());
        send_route(req);
      end
    end

    drain_routes();
    if (book.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
